>>> hdl/line_substring_word_filter_unit_macros.svh
// Assertion helpers shared by the filter's RTL.
`ifndef LINE_SUBSTRING_WORD_FILTER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_WORD_FILTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hdl/lsw_pkg.sv
`default_nettype none

package lsw_pkg;

	// Character codes.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	// Each half of the two-byte wide space.
	localparam logic [7:0] CH_WIDE_SP = 8'hA1;

	// Register map: register i sits at byte address 8*i.
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_WORD_MODE    = 2'd3;

	localparam int LEN_W   = 5;
	localparam int COUNT_W = 32;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       line_end;
	} text_item_t;

	typedef struct packed {
		logic               line_matched;
		logic [COUNT_W-1:0] match_number;
	} result_item_t;

	// What one window cell is asked to do.
	typedef struct packed {
		logic use_pat;   // cell lies inside the pattern span
		logic bound;     // cell holds the byte just before the span
	} cell_role_t;

	typedef struct packed {
		logic eq_ok;
		logic bound_space;
	} cell_stat_t;

	typedef struct packed {
		logic all_eq;
		logic edge_space;
	} win_stat_t;

	typedef struct packed {
		logic done;
		logic matched;
	} line_res_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
			input logic [3:0] k);
		logic [63:0] sel;
		sel = k[3] ? hi : lo;
		return sel[8*k[2:0] +: 8];
	endfunction

endpackage

`default_nettype wire

>>> hdl/lsw_cell.sv
`default_nettype none

// One stage of the text window: holds a byte, passes it on, and checks
// the byte that is arriving against its pattern byte.
module lsw_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift_en,
	input  wire logic [7:0]          shift_in,
	input  wire lsw_pkg::cell_role_t role,
	input  wire logic [7:0]          pat,
	output logic [7:0]               byte_q,
	output lsw_pkg::cell_stat_t      stat
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (shift_en) begin
			byte_q <= shift_in;
		end
	end

	assign stat.eq_ok       = !role.use_pat || (shift_in == pat);
	assign stat.bound_space = role.bound && (shift_in == lsw_pkg::CH_SPACE);

endmodule

`default_nettype wire

>>> hdl/lsw_line.sv
`default_nettype none

// Per-line bookkeeping: trimming, first occurrence and the verdict at line end.
module lsw_line #(
	parameter int LINE_MAX = 8192
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire lsw_pkg::text_item_t               item,
	input  wire logic [lsw_pkg::LEN_W-1:0]         len,
	input  wire logic                              word_mode,
	input  wire logic                              single_a1,
	input  wire lsw_pkg::win_stat_t                win,
	output logic                                   shift_en,
	output lsw_pkg::line_res_t                     res
);

	localparam int POS_W = $clog2(LINE_MAX);
	localparam int D_W   = POS_W + 2;
	localparam int LAST_POS = LINE_MAX - 3;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_PEND,
		PH_CONTENT
	} phase_t;

	phase_t             ph_q, n_ph, e_ph;
	logic [POS_W-1:0]   pos_q, cs_q, lne_q, fhe_q;
	logic [POS_W-1:0]   n_cs, n_lne, n_fhe, e_fhe;
	logic               hit_q, pre_q, fol_q, nul_q;
	logic               n_hit, n_pre, n_fol, n_nul;
	logic               e_hit, e_pre, e_fol;
	logic [POS_W-1:0]   pos_inc, pos_dec, hs;
	logic [D_W-1:0]     diff;
	logic               live, nul_byte, ws, line_done, matched;
	logic [7:0]         b;

	assign b        = item.text_byte;
	assign live     = !nul_q;
	assign nul_byte = (b == lsw_pkg::CH_NUL);
	assign ws       = lsw_pkg::is_ws(b);
	assign pos_inc  = pos_q + POS_W'(1);
	assign pos_dec  = pos_q - POS_W'(1);
	assign diff     = {2'b00, pos_q} + D_W'(1) - D_W'(len);
	assign hs       = diff[POS_W-1:0];
	assign shift_en = accept && live && !nul_byte;
	assign line_done = item.line_end || (pos_q >= POS_W'(LAST_POS));

	always_comb begin
		n_ph  = ph_q;
		n_cs  = cs_q;
		n_lne = lne_q;
		n_fhe = fhe_q;
		n_hit = hit_q;
		n_pre = pre_q;
		n_fol = fol_q;
		n_nul = nul_q;

		if (live && nul_byte) begin
			n_nul = 1'b1;
		end
		if (live && !nul_byte) begin
			unique case (ph_q)
				PH_LEAD: begin
					if (!ws) begin
						if (b == lsw_pkg::CH_WIDE_SP) begin
							n_ph = PH_PEND;
						end else begin
							n_cs = pos_q;
							n_ph = PH_CONTENT;
						end
					end
				end
				PH_PEND: begin
					if (b == lsw_pkg::CH_WIDE_SP) begin
						n_ph = PH_LEAD;
					end
				end
				default: begin
				end
			endcase
			if (!ws) begin
				n_lne = pos_inc;
			end
		end
		// A lone wide-space byte opens the content one position back.
		if (live && ph_q == PH_PEND && b != lsw_pkg::CH_WIDE_SP) begin
			n_cs = pos_dec;
			n_ph = PH_CONTENT;
			if (single_a1 && !hit_q) begin
				n_fhe = pos_q;
				n_hit = 1'b1;
				n_pre = 1'b1;
				n_fol = 1'b0;
			end
		end
		if (live && !nul_byte) begin
			if (n_hit && pos_q == n_fhe && b == lsw_pkg::CH_SPACE) begin
				n_fol = 1'b1;
			end
			if (n_ph == PH_CONTENT && !n_hit && len != '0 && !diff[D_W-1] &&
					hs >= n_cs && win.all_eq) begin
				n_fhe = pos_inc;
				n_hit = 1'b1;
				n_pre = (hs == n_cs) || win.edge_space;
				n_fol = 1'b0;
			end
		end

		// Line end with a wide-space byte still pending.
		e_ph  = n_ph;
		e_fhe = n_fhe;
		e_hit = n_hit;
		e_pre = n_pre;
		e_fol = n_fol;
		if (n_ph == PH_PEND) begin
			e_ph = PH_CONTENT;
			if (single_a1 && !n_hit) begin
				e_fhe = pos_inc;
				e_hit = 1'b1;
				e_pre = 1'b1;
				e_fol = 1'b0;
			end
		end

		matched = 1'b0;
		if (e_ph == PH_CONTENT) begin
			if (len == '0) begin
				matched = !word_mode;
			end else if (e_hit && e_fhe <= n_lne) begin
				matched = !word_mode || (e_pre && ((e_fhe == n_lne) || e_fol));
			end
		end
	end

	assign res.done    = accept && line_done;
	assign res.matched = matched;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_LEAD;
			pos_q <= '0;
			cs_q  <= '0;
			lne_q <= '0;
			fhe_q <= '0;
			hit_q <= 1'b0;
			pre_q <= 1'b0;
			fol_q <= 1'b0;
			nul_q <= 1'b0;
		end else if (accept) begin
			if (line_done) begin
				ph_q  <= PH_LEAD;
				pos_q <= '0;
				cs_q  <= '0;
				lne_q <= '0;
				fhe_q <= '0;
				hit_q <= 1'b0;
				pre_q <= 1'b0;
				fol_q <= 1'b0;
				nul_q <= 1'b0;
			end else begin
				ph_q  <= n_ph;
				pos_q <= pos_inc;
				cs_q  <= n_cs;
				lne_q <= n_lne;
				fhe_q <= n_fhe;
				hit_q <= n_hit;
				pre_q <= n_pre;
				fol_q <= n_fol;
				nul_q <= n_nul;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/lsw_skid.sv
`default_nettype none

// Two-entry result buffer: an output register plus a skid slot.
module lsw_skid (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire lsw_pkg::result_item_t push_item,
	output logic                       valid,
	input  wire logic                  stall,
	output lsw_pkg::result_item_t      item,
	output logic                       full
);

	logic                  main_valid_q, skid_valid_q;
	lsw_pkg::result_item_t main_q, skid_q;
	logic                  pop;

	assign pop   = main_valid_q && !stall;
	assign valid = main_valid_q;
	assign item  = main_q;
	assign full  = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!main_valid_q || pop) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

endmodule

`default_nettype wire

>>> hdl/line_substring_word_filter_unit.sv
// A line's result is registered into the result buffer from the item that closes it.
// Throughput: one item per cycle while text_stall is low, whether or not items end lines.
// The text side stalls only while two results are queued (the skid slot is occupied).
// Reset (arst_n low, asynchronous) clears the window, line state, result queue and count,
// and returns the registers to pattern zero, length one, substring mode.
`default_nettype none

`include "line_substring_word_filter_unit_macros.svh"

module line_substring_word_filter_unit #(
	parameter int PATTERN_MAX = 16,
	parameter int LINE_MAX    = 8192
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lsw_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [63:0]                   pwdata,
	output logic [63:0]                        prdata,
	output logic                               pready,
	// Text items in.
	input  wire logic                          text_valid,
	output logic                               text_stall,
	input  wire lsw_pkg::text_item_t           text,
	// Line results out.
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output lsw_pkg::result_item_t              result
);

	localparam int CELLS = PATTERN_MAX + 1;

	// Configuration registers.
	logic [63:0]               pattern_low_q, pattern_high_q;
	logic [lsw_pkg::LEN_W-1:0] pattern_len_q;
	logic                      word_mode_q;
	logic                      cfg_write;
	logic [lsw_pkg::REG_IDX_W-1:0] reg_idx;

	// Datapath.
	logic                      accept, shift_en, single_a1;
	logic [lsw_pkg::LEN_W-1:0] len;
	logic [7:0]                win_byte [CELLS];
	lsw_pkg::cell_stat_t       cell_stat [CELLS];
	lsw_pkg::win_stat_t        win;
	lsw_pkg::line_res_t        line_res;
	logic [lsw_pkg::COUNT_W-1:0] matched_lines_q, count_next;
	lsw_pkg::result_item_t     res_item;
	logic                      skid_full;

	// The port never waits; the register index is the address over eight.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[lsw_pkg::ADDR_W-1:3];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			pattern_len_q  <= lsw_pkg::LEN_W'(1);
			word_mode_q    <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				lsw_pkg::REG_PATTERN_LOW:  pattern_low_q  <= pwdata;
				lsw_pkg::REG_PATTERN_HIGH: pattern_high_q <= pwdata;
				lsw_pkg::REG_PATTERN_LEN:  pattern_len_q  <= pwdata[lsw_pkg::LEN_W-1:0];
				lsw_pkg::REG_WORD_MODE:    word_mode_q    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lsw_pkg::REG_PATTERN_LOW:  prdata = pattern_low_q;
			lsw_pkg::REG_PATTERN_HIGH: prdata = pattern_high_q;
			lsw_pkg::REG_PATTERN_LEN:  prdata = {{(64-lsw_pkg::LEN_W){1'b0}}, pattern_len_q};
			lsw_pkg::REG_WORD_MODE:    prdata = {63'd0, word_mode_q};
			default:                   prdata = '0;
		endcase
	end

	// Lengths beyond PATTERN_MAX act as PATTERN_MAX.
	assign len = (pattern_len_q > lsw_pkg::LEN_W'(PATTERN_MAX)) ?
		lsw_pkg::LEN_W'(PATTERN_MAX) : pattern_len_q;

	// A one-byte wide-space pattern can be hit by a lone wide-space byte that
	// only turns out to be content once the next byte or the line end arrives.
	assign single_a1 = (len == lsw_pkg::LEN_W'(1)) &&
		(pattern_low_q[7:0] == lsw_pkg::CH_WIDE_SP);

	assign accept = text_valid && !text_stall;

	// The window is a row of cells. Cell 0 takes the new byte and each cell hands
	// its byte to the next one on every kept byte. Cell j checks the byte arriving
	// at it against pattern byte len-1-j, so the whole row agrees exactly when the
	// newest len bytes spell the pattern. The cell at position len sees the byte
	// just ahead of that span, which decides whether the hit is space-delimited.
	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		lsw_pkg::cell_role_t role;
		logic [7:0]          in_byte;
		logic [7:0]          pat;

		assign role.use_pat = lsw_pkg::LEN_W'(j) < len;
		assign role.bound   = lsw_pkg::LEN_W'(j) == len;
		assign pat = lsw_pkg::pat_byte(pattern_low_q, pattern_high_q,
			4'(len - lsw_pkg::LEN_W'(j) - lsw_pkg::LEN_W'(1)));

		if (j == 0) begin : g_head
			assign in_byte = text.text_byte;
		end else begin : g_body
			assign in_byte = win_byte[j-1];
		end

		lsw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.shift_in (in_byte),
			.role     (role),
			.pat      (pat),
			.byte_q   (win_byte[j]),
			.stat     (cell_stat[j])
		);
	end

	always_comb begin
		win.all_eq     = 1'b1;
		win.edge_space = 1'b0;
		for (int j = 0; j < CELLS; j++) begin
			win.all_eq     = win.all_eq && cell_stat[j].eq_ok;
			win.edge_space = win.edge_space || cell_stat[j].bound_space;
		end
	end

	// Trimming, first-hit tracking and the verdict at the end of each line.
	lsw_line #(
		.LINE_MAX (LINE_MAX)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (text),
		.len       (len),
		.word_mode (word_mode_q),
		.single_a1 (single_a1),
		.win       (win),
		.shift_en  (shift_en),
		.res       (line_res)
	);

	// Saturating count of matching lines; the item carries the updated value.
	assign count_next = (line_res.matched && (matched_lines_q != '1)) ?
		matched_lines_q + lsw_pkg::COUNT_W'(1) : matched_lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_lines_q <= '0;
		end else if (line_res.done) begin
			matched_lines_q <= count_next;
		end
	end

	assign res_item.line_matched = line_res.matched;
	assign res_item.match_number = count_next;

	// The skid slot keeps a result produced in the same cycle that the output
	// register is found full and stalled; text is held off only while it is occupied.
	lsw_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (line_res.done),
		.push_item (res_item),
		.valid     (result_valid),
		.stall     (result_stall),
		.item      (result),
		.full      (skid_full)
	);

	assign text_stall = skid_full;

	`LSW_ASSERT_NEXT(a_count_monotonic, clk, arst_n, 1'b1, matched_lines_q >= $past(matched_lines_q))
	`LSW_ASSERT_NEXT(a_count_hold, clk, arst_n, !(line_res.done && line_res.matched), $stable(matched_lines_q))
	`LSW_ASSERT_NOW(a_no_push_when_full, clk, arst_n, skid_full, !line_res.done)
	`LSW_ASSERT_NOW(a_skid_behind_main, clk, arst_n, skid_full, result_valid)

endmodule

`default_nettype wire
